### design/sorted_priority_queue_defines.svh
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared property wrappers for the queue's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define SPQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Item types, entry type and codes shared by the cell row and the top level.
// ----------------------------------------------------------------------------
package spq_pkg;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  localparam logic signed [31:0] EMPTY_VALUE = 32'shFFFF_FFFF;

  typedef struct packed {
    op_t                operation;
    logic signed [31:0] item_value;
    logic signed [31:0] item_priority;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    status_t            status;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] prio;
  } entry_t;

  // Row-wide command, already gated by full and empty
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctl_t;

endpackage

### design/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry; on enqueue shifts right or captures the new item, on
// dequeue takes the entry of its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic              clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  spq_pkg::entry_t   new_entry,
  input  logic              occupied,
  input  logic              left_disp,
  input  spq_pkg::entry_t   left_entry,
  input  spq_pkg::entry_t   right_entry,
  output logic              disp,
  output spq_pkg::entry_t   entry
);
  import spq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  // Displaced cells form a suffix of the row since entries stay sorted
  assign disp  = !occupied || (entry_r.prio <= new_entry.prio);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.enq && disp) begin
      entry_nxt = left_disp ? left_entry : new_entry;
    end else if (ctl.deq) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

### design/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue kept sorted in a row of cells, highest priority at cell 0.
// ----------------------------------------------------------------------------
//  channel   ports                     handshake
//  input     in_item                   start high, busy low at clock edge
//  result    out_item                  out_valid high for one cycle
//
//  One item per cycle; every cell compares and shifts in the same edge.
//  The result appears on the cycle after the item is taken, for one cycle.
//  busy stays low; the receiver cannot stall, none is needed.
//  Reset empties the queue by clearing the entry count, not the entries; it also clears out_valid.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  spq_pkg::in_item_t  in_item,
  output logic               out_valid,
  output spq_pkg::out_item_t out_item
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          out_valid_r;
  out_item_t     out_item_r;
  out_item_t     out_item_nxt;

  logic      accept;
  logic      full;
  logic      empty;
  logic      drop_full;
  logic      res_full;
  cell_ctl_t ctl;
  entry_t    new_entry;
  entry_t    entry_w [DEPTH];
  logic      disp_w  [DEPTH];

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign full      = (count_r == CNT_FULL);
  assign empty     = (count_r == '0);
  assign ctl.enq   = accept && (in_item.operation == OP_ENQ) && !full;
  assign ctl.deq   = accept && (in_item.operation == OP_DEQ) && !empty;
  assign new_entry = '{value: in_item.item_value, prio: in_item.item_priority};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_d;

    if (i == 0) begin : g_head
      assign left_d = 1'b0;
      assign left_e = new_entry;
    end else begin : g_mid
      assign left_d = disp_w[i-1];
      assign left_e = entry_w[i-1];
    end

    // Last cell empties on dequeue; its content no longer counts
    if (i == DEPTH - 1) begin : g_tail
      assign right_e = new_entry;
    end else begin : g_body
      assign right_e = entry_w[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .new_entry  (new_entry),
      .occupied   (CW'(i) < count_r),
      .left_disp  (left_d),
      .left_entry (left_e),
      .right_entry(right_e),
      .disp       (disp_w[i]),
      .entry      (entry_w[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.enq) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.deq) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    out_item_nxt = out_item_r;
    if (accept) begin
      unique case (in_item.operation)
        OP_ENQ: begin
          out_item_nxt.out_value = '0;
          out_item_nxt.status    = full ? STATUS_FULL : STATUS_OK;
        end
        OP_DEQ: begin
          out_item_nxt.out_value = empty ? EMPTY_VALUE : entry_w[0].value;
          out_item_nxt.status    = empty ? STATUS_EMPTY : STATUS_OK;
        end
        default: begin
          out_item_nxt = out_item_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign drop_full = accept && (in_item.operation == OP_ENQ) && full;
  assign res_full  = (out_item.status == STATUS_FULL);

  `SPQ_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CNT_FULL, "entry count above depth")
  `SPQ_ASSERT_NEXT(a_result_follows, accept, out_valid, "accepted item gave no result")
  `SPQ_ASSERT_NEXT(a_full_drop, drop_full, (count_r == $past(count_r)) && res_full, "full kept")
  `SPQ_ASSERT_SAME(a_head_order, count_r > CW'(1), entry_w[0].prio >= entry_w[1].prio, "bad head")

endmodule

### tb/sorted_priority_queue_test.sv
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives enqueue and dequeue commands into the queue and mirrors its sorted
// store in a local model. Each result is checked against the oldest predicted
// one. Traffic runs in bursts that fill and drain the store, so full drops,
// empty dequeues and equal-priority ordering all come up often.
// ----------------------------------------------------------------------------
module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam int DEPTH       = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_MAX  = 10;
  localparam int PHASE_ITEMS = 460;

  class queue_mirror;
    typedef struct packed {
      logic signed [31:0] val;
      logic signed [31:0] rank;
    } slot_t;

    slot_t     slots[$];
    out_item_t pending_results[$];
    int        mismatches;
    int        enq_count;
    int        deq_count;
    int        full_count;
    int        empty_count;
    int        peak_fill;

    function void apply_item(in_item_t it);
      out_item_t res;
      slot_t     s;
      int        pos;
      res.out_value = '0;
      res.status    = STATUS_OK;
      if (it.operation == OP_ENQ) begin
        enq_count++;
        if (slots.size() >= DEPTH) begin
          res.status = STATUS_FULL;
          full_count++;
        end else begin
          // place ahead of the first entry whose priority is not above ours
          pos = 0;
          while (pos < slots.size() && $signed(slots[pos].rank) > $signed(it.item_priority))
            pos++;
          s.val  = it.item_value;
          s.rank = it.item_priority;
          slots.insert(pos, s);
          if (slots.size() > peak_fill) peak_fill = slots.size();
        end
      end else begin
        deq_count++;
        if (slots.size() == 0) begin
          res.out_value = EMPTY_VALUE;
          res.status    = STATUS_EMPTY;
          empty_count++;
        end else begin
          s             = slots.pop_front();
          res.out_value = s.val;
        end
      end
      pending_results.push_back(res);
    endfunction

    function void report(string what, out_item_t want, out_item_t got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("[%0t] %s: expected value %0d status %0d, got value %0d status %0d",
                 $time, what, want.out_value, want.status, got.out_value, got.status);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        want = '0;
        report("result with nothing pending", want, got);
      end else begin
        want = pending_results.pop_front();
        if (got.out_value !== want.out_value || got.status !== want.status)
          report("result mismatch", want, got);
      end
    endfunction

    function void flush();
      out_item_t want;
      while (pending_results.size() != 0) begin
        want = pending_results.pop_front();
        report("result never arrived", want, '0);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  queue_mirror mirror;
  int          stall_cycles;

  sorted_priority_queue #(.DEPTH(DEPTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Note accepted items, check results and watch for a hang
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else begin
      if (start && !busy) mirror.apply_item(in_item);
      if (out_valid) mirror.check_result(out_item);
      if ((start && !busy) || out_valid) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("sorted_priority_queue_test: FAIL");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic send_op(op_t op, logic signed [31:0] val, logic signed [31:0] pri,
                         int idle_pct);
    in_item_t it;
    it.operation     = op;
    it.item_value    = val;
    it.item_priority = pri;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Often a narrow band so ties are common, sometimes the extremes, else any value
  function automatic logic signed [31:0] pick_priority();
    case ($urandom_range(9))
      0:          return 32'sh8000_0000;
      1:          return 32'sh7FFF_FFFF;
      2, 3, 4, 5: return $signed($urandom_range(6)) - 32'sd3;
      default:    return $urandom;
    endcase
  endfunction

  task automatic run_phase(int n_items, int idle_pct);
    int left;
    int seg;
    int enq_pct;
    int seg_idle;
    left = n_items;
    while (left > 0) begin
      seg = $urandom_range(8, 40);
      // fill-heavy, drain-heavy or balanced burst
      case ($urandom_range(2))
        0:       enq_pct = 80;
        1:       enq_pct = 20;
        default: enq_pct = 50;
      endcase
      seg_idle = ($urandom_range(4) == 0) ? 0 : idle_pct;
      for (int k = 0; k < seg && left > 0; k++) begin
        send_op(($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ,
                $urandom, pick_priority(), seg_idle);
        left--;
      end
    end
  endtask

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    mirror  = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // dequeue from empty, extreme priorities, ties at zero and at the top
    send_op(OP_DEQ, 32'sd5, 32'sd5, 0);
    send_op(OP_ENQ, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
    send_op(OP_ENQ, 32'sh8000_0000, 32'sh7FFF_FFFF, 0);
    send_op(OP_ENQ, 32'sd1, 32'sd0, 0);
    send_op(OP_ENQ, 32'sd2, 32'sd0, 0);
    send_op(OP_ENQ, 32'sd3, -32'sd1, 0);
    send_op(OP_ENQ, -32'sd1, 32'sd0, 0);
    send_op(OP_ENQ, 32'sd0, 32'sh7FFF_FFFF, 0);
    repeat (8) send_op(OP_DEQ, $urandom, $urandom, 0);

    run_phase(PHASE_ITEMS, 0);
    run_phase(PHASE_ITEMS, 69);
    run_phase(PHASE_ITEMS, 0);
    run_phase(PHASE_ITEMS, 14);
    start <= 1'b0;

    @(negedge clk);
    while (mirror.pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    mirror.flush();

    $display("covered %0d enqueues (%0d dropped as full) and %0d dequeues (%0d on empty)",
             mirror.enq_count, mirror.full_count, mirror.deq_count, mirror.empty_count);
    $display("peak fill %0d of %0d entries, %0d result mismatches",
             mirror.peak_fill, DEPTH, mirror.mismatches);
    if (mirror.mismatches == 0) begin
      $display("sorted_priority_queue_test: PASS");
    end else begin
      $display("sorted_priority_queue_test: FAIL");
    end
    $finish;
  end

endmodule
